@@ hdl/symmetric_difference_count_macros.svh @@
// Assertion helpers for the files that check their own logic.
// Every check is clocked on clk and is switched off while rst_n is low.
`ifndef SYMMETRIC_DIFFERENCE_COUNT_MACROS_SVH
`define SYMMETRIC_DIFFERENCE_COUNT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SDC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/sdc_pkg.sv @@
`default_nettype none

package sdc_pkg;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 6;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;

  // Request kinds carried on the input tuser.
  typedef enum logic [1:0] {
    OP_APPEND_A = 2'd0,
    OP_APPEND_B = 2'd1,
    OP_EVAL     = 2'd2
  } sdc_op_t;

  // Status from the scan sequencer to the top level.
  typedef struct packed {
    logic busy;
    logic done;
  } sdc_status_t;

endpackage

`default_nettype wire

@@ hdl/sdc_set_mem.sv @@
`default_nettype none

// One set store: a single write port and a registered read port.
module sdc_set_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [AW-1:0]               waddr,
  input  wire logic [sdc_pkg::VALUE_W-1:0] wdata,
  input  wire logic [AW-1:0]               raddr,
  output logic      [sdc_pkg::VALUE_W-1:0] rdata
);

  import sdc_pkg::*;

  logic [VALUE_W-1:0] mem [DEPTH];
  logic [VALUE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ hdl/sdc_scan.sv @@
`default_nettype none

// Evaluation sequencer. For every element of the own set it loads the element
// as a key, then walks both stores in step: earlier own entries flag a
// duplicate, other-set entries flag a shared value.
module sdc_scan #(
  parameter int MAX_ITEMS = 16,
  parameter int AW        = 4,
  parameter int SW        = 5
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [SW-1:0]               n_a,
  input  wire logic [SW-1:0]               n_b,
  input  wire logic                        out_free,
  input  wire logic [sdc_pkg::VALUE_W-1:0] a_rdata,
  input  wire logic [sdc_pkg::VALUE_W-1:0] b_rdata,
  output logic      [AW-1:0]               rd_addr,
  output sdc_pkg::sdc_status_t             status,
  output logic      [sdc_pkg::COUNT_W-1:0] count
);

  import sdc_pkg::*;

  localparam int CW = $clog2(2 * MAX_ITEMS + 1);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PASS  = 6'b000010,
    ST_KEY   = 6'b000100,
    ST_LATCH = 6'b001000,
    ST_SCAN  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t             state_r, state_nxt;
  logic               pass_r, pass_nxt;
  logic [SW-1:0]      na_r, na_nxt, nb_r, nb_nxt;
  logic [AW-1:0]      i_r, i_nxt, j_r, j_nxt;
  logic [VALUE_W-1:0] key_r, key_nxt;
  logic               dup_r, dup_nxt, found_r, found_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;

  logic [SW-1:0]      n_own, n_other, i_ext, j_ext, scan_len;
  logic [VALUE_W-1:0] own_d, oth_d;
  logic               hit_dup, hit_found, dup_all, found_all, last_i, last_j;
  logic [31:0]        cnt_ext;

  assign n_own    = pass_r ? nb_r : na_r;
  assign n_other  = pass_r ? na_r : nb_r;
  assign own_d    = pass_r ? b_rdata : a_rdata;
  assign oth_d    = pass_r ? a_rdata : b_rdata;
  assign i_ext    = SW'(i_r);
  assign j_ext    = SW'(j_r);
  assign scan_len = (i_ext > n_other) ? i_ext : n_other;

  assign hit_dup   = (j_ext < i_ext) && (own_d == key_r);
  assign hit_found = (j_ext < n_other) && (oth_d == key_r);
  assign dup_all   = dup_r | hit_dup;
  assign found_all = found_r | hit_found;
  assign last_j    = (j_ext + SW'(1)) == scan_len;
  assign last_i    = (i_ext + SW'(1)) == n_own;

  always_comb begin
    case (state_r)
      ST_KEY:  rd_addr = i_r;
      ST_SCAN: rd_addr = last_j ? '0 : j_r + AW'(1);
      default: rd_addr = '0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    pass_nxt  = pass_r;
    na_nxt    = na_r;
    nb_nxt    = nb_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    key_nxt   = key_r;
    dup_nxt   = dup_r;
    found_nxt = found_r;
    cnt_nxt   = cnt_r;
    status    = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          na_nxt    = n_a;
          nb_nxt    = n_b;
          pass_nxt  = 1'b0;
          cnt_nxt   = '0;
          state_nxt = ST_PASS;
        end
      end
      ST_PASS: begin
        if (n_own == '0) begin
          if (pass_r) begin
            state_nxt = ST_DONE;
          end else begin
            pass_nxt = 1'b1;
          end
        end else begin
          i_nxt     = '0;
          state_nxt = ST_KEY;
        end
      end
      ST_KEY: begin
        state_nxt = ST_LATCH;
      end
      ST_LATCH: begin
        key_nxt   = own_d;
        dup_nxt   = 1'b0;
        found_nxt = 1'b0;
        j_nxt     = '0;
        state_nxt = ST_SCAN;
        // The very first element against an empty other set has nothing to scan.
        if (scan_len == '0) begin
          cnt_nxt = cnt_r + CW'(1);
          if (last_i) begin
            state_nxt = pass_r ? ST_DONE : ST_PASS;
            pass_nxt  = 1'b1;
          end else begin
            i_nxt     = i_r + AW'(1);
            state_nxt = ST_KEY;
          end
        end
      end
      ST_SCAN: begin
        dup_nxt   = dup_all;
        found_nxt = found_all;
        if (last_j) begin
          if (!dup_all && !found_all) begin
            cnt_nxt = cnt_r + CW'(1);
          end
          if (last_i) begin
            state_nxt = pass_r ? ST_DONE : ST_PASS;
            pass_nxt  = 1'b1;
          end else begin
            i_nxt     = i_r + AW'(1);
            state_nxt = ST_KEY;
          end
        end else begin
          j_nxt = j_r + AW'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          status.done = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    status.busy = (state_r != ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pass_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pass_r  <= pass_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    na_r    <= na_nxt;
    nb_r    <= nb_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    key_r   <= key_nxt;
    dup_r   <= dup_nxt;
    found_r <= found_nxt;
  end

  assign cnt_ext = 32'(cnt_r);
  assign count   = (cnt_ext > 32'(COUNT_MAX)) ? COUNT_MAX : cnt_ext[COUNT_W-1:0];

endmodule

`default_nettype wire

@@ hdl/symmetric_difference_count.sv @@
// Appends produce no result; one request is taken per cycle while the sequencer is idle.
// An evaluate request occupies the scan sequencer, and holds in_tready low, for the
// pairwise walk over the two set memories through their single read ports and while
// an older result still waits in the output register; out_tvalid rises in the cycle
// after the sequencer hands over its result.
// rst_n (synchronous, active low) empties both sets and clears the overflow flag.
`default_nettype none

`include "symmetric_difference_count_macros.svh"

module symmetric_difference_count #(
  parameter int MAX_ITEMS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] value
  input  wire logic [1:0]  in_tuser,   // [1:0] opcode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [5:0] distinct_only_one_count, [7:6] zero
  output logic [0:0]       out_tuser   // [0] overflow
);

  import sdc_pkg::*;

  // Address width of the set memories and width of the element counters,
  // which must be able to hold MAX_ITEMS itself.
  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int SW = $clog2(MAX_ITEMS + 1);

  sdc_op_t            op;
  logic               in_acc, a_full, b_full, a_we, b_we, start, out_free;
  logic [SW-1:0]      size_a_r, size_a_nxt, size_b_r, size_b_nxt;
  logic               ovf_r, ovf_nxt;
  logic               eval_ovf_r;
  logic               out_valid_r;
  logic [COUNT_W-1:0] out_count_r;
  logic               out_ovf_r;
  logic [AW-1:0]      rd_addr;
  logic [VALUE_W-1:0] a_rdata, b_rdata;
  logic [COUNT_W-1:0] scan_count;
  sdc_status_t        scan_status;

  // A request is taken whenever the sequencer is idle. Appends may still be
  // taken while a previous result waits in the output register.
  assign in_tready = !scan_status.busy;
  assign in_acc    = in_tvalid && in_tready;
  assign op        = sdc_op_t'(in_tuser);

  assign a_full = (size_a_r == SW'(MAX_ITEMS));
  assign b_full = (size_b_r == SW'(MAX_ITEMS));

  // Opcode three matches no arm and leaves everything untouched.
  always_comb begin
    a_we       = 1'b0;
    b_we       = 1'b0;
    start      = 1'b0;
    size_a_nxt = size_a_r;
    size_b_nxt = size_b_r;
    ovf_nxt    = ovf_r;
    if (in_acc) begin
      case (op)
        OP_APPEND_A: begin
          if (a_full) begin
            ovf_nxt = 1'b1;
          end else begin
            a_we       = 1'b1;
            size_a_nxt = size_a_r + SW'(1);
          end
        end
        OP_APPEND_B: begin
          if (b_full) begin
            ovf_nxt = 1'b1;
          end else begin
            b_we       = 1'b1;
            size_b_nxt = size_b_r + SW'(1);
          end
        end
        OP_EVAL: begin
          // The sequencer latches the sizes, so both sets empty right away.
          start      = 1'b1;
          size_a_nxt = '0;
          size_b_nxt = '0;
          ovf_nxt    = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_a_r <= '0;
      size_b_r <= '0;
      ovf_r    <= 1'b0;
    end else begin
      size_a_r <= size_a_nxt;
      size_b_r <= size_b_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

  // The overflow flag belongs to the evaluate request that reports it.
  always_ff @(posedge clk) begin
    if (start) begin
      eval_ovf_r <= ovf_r;
    end
  end

  sdc_set_mem #(
    .DEPTH (MAX_ITEMS),
    .AW    (AW)
  ) u_set_a (
    .clk   (clk),
    .we    (a_we),
    .waddr (size_a_r[AW-1:0]),
    .wdata (in_tdata),
    .raddr (rd_addr),
    .rdata (a_rdata)
  );

  sdc_set_mem #(
    .DEPTH (MAX_ITEMS),
    .AW    (AW)
  ) u_set_b (
    .clk   (clk),
    .we    (b_we),
    .waddr (size_b_r[AW-1:0]),
    .wdata (in_tdata),
    .raddr (rd_addr),
    .rdata (b_rdata)
  );

  sdc_scan #(
    .MAX_ITEMS (MAX_ITEMS),
    .AW        (AW),
    .SW        (SW)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .n_a      (size_a_r),
    .n_b      (size_b_r),
    .out_free (out_free),
    .a_rdata  (a_rdata),
    .b_rdata  (b_rdata),
    .rd_addr  (rd_addr),
    .status   (scan_status),
    .count    (scan_count)
  );

  // Output register: the sequencer hands over its count only when the slot
  // is empty or is being emptied in the same cycle.
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (scan_status.done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_status.done) begin
      out_count_r <= scan_count;
      out_ovf_r   <= eval_ovf_r;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = 8'(out_count_r);
  assign out_tuser[0] = out_ovf_r;

  // An evaluate request empties both sets and stops further requests.
  `SDC_ASSERT_NEXT(a_eval_clears, start, (size_a_r == '0) && (size_b_r == '0) && !in_tready, "evaluate did not clear the sets or block requests")

  // A result is only handed over when the output register can take it.
  `SDC_ASSERT_SAME(a_done_slot_free, scan_status.done, out_free, "result handed over while the output register is full")

  // An append to a full set A must raise the overflow flag.
  `SDC_ASSERT_NEXT(a_full_sets_ovf, in_acc && (op == OP_APPEND_A) && a_full, ovf_r, "dropped append did not raise overflow")

  // The element counters never pass the set capacity.
  `SDC_ASSERT_SAME(a_size_bound, 1'b1, (size_a_r <= SW'(MAX_ITEMS)) && (size_b_r <= SW'(MAX_ITEMS)), "set size beyond capacity")

endmodule

`default_nettype wire

@@ verif/symmetric_difference_count_checker.sv @@
`timescale 1ns / 1ps

module symmetric_difference_count_checker #(
  parameter int SET_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [31:0] in_tdata,
  input  logic [1:0] in_tuser,
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,
  input  logic [0:0] out_tuser,
  output int         mismatch_total,
  output int         tallies_outstanding
);
  import sdc_pkg::*;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               overflow;
  } tally_t;

  // Shadow copy of both sets; index 0 is set A, index 1 is set B.
  logic [VALUE_W-1:0] set_members [2][SET_DEPTH];
  int                 set_fill [2];
  logic               drop_seen;
  tally_t             expected_tallies [$];
  int                 errors = 0;

  assign mismatch_total = errors;

  // A value counts once, at its first copy, and only if the other set lacks it.
  function automatic tally_t evaluate_sets();
    tally_t t;
    int     total;
    int     s;
    int     i;
    int     j;
    bit     repeated;
    bit     shared;
    total = 0;
    for (s = 0; s < 2; s++) begin
      for (i = 0; i < set_fill[s]; i++) begin
        repeated = 1'b0;
        shared = 1'b0;
        for (j = 0; j < i; j++) begin
          if (set_members[s][j] == set_members[s][i]) repeated = 1'b1;
        end
        for (j = 0; j < set_fill[1-s]; j++) begin
          if (set_members[1-s][j] == set_members[s][i]) shared = 1'b1;
        end
        if (!repeated && !shared) total++;
      end
    end
    if (total > COUNT_MAX) total = COUNT_MAX;
    t.count = total[COUNT_W-1:0];
    t.overflow = drop_seen;
    return t;
  endfunction

  always @(posedge clk) begin : monitor
    tally_t want;
    int     side;
    if (!rst_n) begin
      set_fill[0] = 0;
      set_fill[1] = 0;
      drop_seen = 1'b0;
      expected_tallies.delete();
    end else begin
      // Results are taken before requests so that a result arriving on the
      // same edge as an evaluate is matched against older expectations.
      if (out_tvalid && out_tready) begin
        if (expected_tallies.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none, got count %0d overflow %0b",
                   $time, out_tdata, out_tuser[0]);
        end else begin
          want = expected_tallies.pop_front();
          if (out_tdata !== {2'b00, want.count}) begin
            errors++;
            $display("%0t: count mismatch: expected %0d, got %0d",
                     $time, want.count, out_tdata);
          end
          if (out_tuser[0] !== want.overflow) begin
            errors++;
            $display("%0t: overflow mismatch: expected %0b, got %0b",
                     $time, want.overflow, out_tuser[0]);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        case (in_tuser)
          OP_APPEND_A, OP_APPEND_B: begin
            side = (in_tuser == OP_APPEND_B) ? 1 : 0;
            if (set_fill[side] >= SET_DEPTH) begin
              drop_seen = 1'b1;
            end else begin
              set_members[side][set_fill[side]] = in_tdata;
              set_fill[side]++;
            end
          end
          OP_EVAL: begin
            expected_tallies.push_back(evaluate_sets());
            set_fill[0] = 0;
            set_fill[1] = 0;
            drop_seen = 1'b0;
          end
          default: begin
          end
        endcase
      end
    end
    tallies_outstanding <= expected_tallies.size();
  end

endmodule

@@ verif/symmetric_difference_count_test.sv @@
`timescale 1ns / 1ps

// Stimulus and verdict for the symmetric difference counter. The checker
// module beside the block watches both streams, keeps its own copy of the two
// sets and compares every result; this module only produces requests, toggles
// the result-side ready, and reports the outcome.
module symmetric_difference_count_test;
  import sdc_pkg::*;

  localparam int SET_DEPTH = 16;
  // Number of append and evaluate requests to issue; undefined opcodes do not
  // count toward it.
  localparam int REQUEST_TARGET = 1300;
  // Long enough for the longest walk, so this covers any request
  // still in flight after the last expected result.
  localparam int DRAIN_CYCLES = 600;
  // Opcode three has no meaning; the block must accept it and ignore it.
  localparam logic [1:0] OP_UNDEFINED = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic [31:0] in_tdata = '0;
  logic [1:0]  in_tuser = OP_APPEND_A;
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [7:0]  out_tdata;
  logic [0:0]  out_tuser;
  int          mismatch_total;
  int          tallies_outstanding;

  // Percentages of cycles in which each side holds back.
  int sender_idle_pct = 14;
  int receiver_idle_pct = 54;
  int requests_sent = 0;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
  end

  symmetric_difference_count #(
    .MAX_ITEMS(SET_DEPTH)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  symmetric_difference_count_checker #(
    .SET_DEPTH(SET_DEPTH)
  ) u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_tvalid          (in_tvalid),
    .in_tready          (in_tready),
    .in_tdata           (in_tdata),
    .in_tuser           (in_tuser),
    .out_tvalid         (out_tvalid),
    .out_tready         (out_tready),
    .out_tdata          (out_tdata),
    .out_tuser          (out_tuser),
    .mismatch_total     (mismatch_total),
    .tallies_outstanding(tallies_outstanding)
  );

  // Boundary values of a signed 32-bit element, plus alternating bit patterns
  // and a repeat of the largest value so that duplicates show up early.
  function automatic logic [31:0] corner_value(input int idx);
    case (idx)
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      4:       return 32'h0000_0001;
      5:       return 32'h5555_5555;
      6:       return 32'hAAAA_AAAA;
      default: return 32'h7FFF_FFFF;
    endcase
  endfunction

  // Offers one request and returns on the edge where it is accepted. Valid is
  // only lowered for an idle cycle, so back-to-back requests keep it high.
  task automatic send_request(input logic [1:0] op, input logic [31:0] value);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (op != OP_UNDEFINED) requests_sent++;
  endtask

  // Holds the input side quiet until every pending count has come back.
  // The first edge lets the checker register an evaluate accepted just now.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tallies_outstanding != 0) @(posedge clk);
  endtask

  // Builds one pair of sets and usually evaluates them. Values are drawn
  // mostly from a small pool so that duplicates inside a set and values shared
  // between the sets are common; the rest are fully random. Some pairs are
  // empty, some run past the set depth, and a few skip the evaluate so that
  // their contents carry into the next pair.
  task automatic run_set_pair();
    logic [31:0] pool [6];
    logic [31:0] pick;
    int          a_left;
    int          b_left;
    int          shape;
    int          k;
    shape = $urandom_range(0, 99);
    if (shape < 6) begin
      a_left = 0;
      b_left = 0;
    end else if (shape < 18) begin
      a_left = $urandom_range(14, 20);
      b_left = $urandom_range(0, 20);
    end else if (shape < 26) begin
      a_left = $urandom_range(12, 16);
      b_left = $urandom_range(12, 16);
    end else begin
      a_left = $urandom_range(0, 7);
      b_left = $urandom_range(0, 7);
    end
    for (k = 0; k < 6; k++) begin
      shape = $urandom_range(0, 99);
      if (shape < 30) pool[k] = corner_value($urandom_range(0, 7));
      else if (shape < 60) pool[k] = $urandom_range(0, 15);
      else pool[k] = $urandom;
    end
    while (a_left + b_left > 0) begin
      if ($urandom_range(0, 99) < 3) send_request(OP_UNDEFINED, $urandom);
      pick = ($urandom_range(0, 99) < 75) ? pool[$urandom_range(0, 5)] : $urandom;
      if (b_left == 0 || (a_left != 0 && $urandom_range(0, 1) == 1)) begin
        send_request(OP_APPEND_A, pick);
        a_left--;
      end else begin
        send_request(OP_APPEND_B, pick);
        b_left--;
      end
    end
    if ($urandom_range(0, 99) < 95) send_request(OP_EVAL, $urandom);
  endtask

  initial begin : stimulus
    int phase;
    int k;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Evaluate straight out of reset: both sets are empty.
    send_request(OP_EVAL, 32'hFFFF_FFFF);
    // An undefined opcode must leave the empty sets alone.
    send_request(OP_UNDEFINED, $urandom);
    send_request(OP_EVAL, 32'h0000_0000);
    // Fill set A with the boundary values and random ones, then push one more
    // so the append to a full set is dropped and flagged.
    for (k = 0; k < SET_DEPTH + 1; k++) begin
      send_request(OP_APPEND_A, (k < 8) ? corner_value(k) : $urandom);
    end
    // Set B shares some of A's values, holds one of its own, and sees a
    // stray undefined request in the middle.
    send_request(OP_APPEND_B, corner_value(1));
    send_request(OP_UNDEFINED, corner_value(0));
    send_request(OP_APPEND_B, corner_value(3));
    send_request(OP_APPEND_B, 32'h0000_0002);
    send_request(OP_EVAL, corner_value(0));
    drain_results();

    // Three random phases: light sender idling with a slow receiver, then
    // the reverse, then full rate on both sides. Each phase ends by letting
    // every outstanding result arrive before the next one starts.
    for (phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 54 : 0;
      receiver_idle_pct = (phase == 0) ? 54 : (phase == 1) ? 14 : 0;
      while (requests_sent < (phase + 1) * REQUEST_TARGET / 3) run_set_pair();
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_total == 0 && tallies_outstanding == 0) begin
      $display("[symmetric_difference_count] OK");
    end else begin
      $display("[symmetric_difference_count] ERROR");
    end
    $finish;
  end

  // Hang guard. A correct run with every pair full and both sides at their
  // worst stalls stays far below this.
  initial begin
    #40ms;
    $display("[symmetric_difference_count] ERROR");
    $finish;
  end

endmodule
